### rtl/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

    localparam int MAX_CHANNELS = 12;
    localparam int FRAME_BYTES  = 16;

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int LAST_POS  = FRAME_BYTES - 1;
    localparam int NUM_SLOTS = (FRAME_BYTES - 2) / 2;

    localparam int CH_W  = 4;
    localparam int VAL_W = 11;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_READ = 1'b1;

    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] REG_HIRES_MODE  = 2'd0;
    localparam logic [1:0] REG_CHANNELS    = 2'd1;
    localparam logic [1:0] REG_MIN_COMMAND = 2'd2;
    localparam logic [1:0] REG_RESYNC_GAP  = 2'd3;

    localparam logic [3:0]  CHANNELS_RESET = 4'd7;
    localparam logic [15:0] RESYNC_RESET   = 16'd5000;
    localparam logic [11:0] PULSE_OFFSET   = 12'd1000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
        logic [3:0]  read_channel;
    } rcfd_in_t;

    typedef struct packed {
        logic        frame_done;
        logic [15:0] channel_value;
    } rcfd_out_t;

    typedef struct packed {
        logic        hires_mode;
        logic [3:0]  channels_in_use;
        logic [15:0] min_command;
        logic [15:0] resync_gap_us;
    } rcfd_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]  idx;
        logic [VAL_W-1:0] val;
    } rcfd_slot_t;

    typedef struct packed {
        logic                        decode;
        rcfd_slot_t [NUM_SLOTS-1:0]  slots;
    } rcfd_decode_t;

endpackage

### rtl/rcfd_frame_asm.sv
`timescale 1ns / 1ps

module rcfd_frame_asm
    import rcfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         byte_en,
    input  logic [7:0]   rx_byte,
    input  logic [31:0]  time_us,
    input  rcfd_cfg_t    cfg,
    output logic         at_last,
    output rcfd_decode_t dec
);

    logic [7:0]       bytes_reg [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      last_time_reg;
    logic [31:0]      gap;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       hi_b, lo_b;

    always_comb begin
        gap      = time_us - last_time_reg;
        pos_eff  = (gap > {16'd0, cfg.resync_gap_us}) ? '0 : pos_reg;
        at_last  = (pos_eff == POS_W'(LAST_POS));
        pos_next = at_last ? pos_eff : pos_eff + POS_W'(1);
    end

    always_comb begin
        dec.decode = byte_en && at_last;
        hi_b = '0;
        lo_b = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            hi_b = bytes_reg[2 + 2 * k];
            lo_b = ((3 + 2 * k) == LAST_POS) ? rx_byte : bytes_reg[3 + 2 * k];
            if (cfg.hires_mode) begin
                dec.slots[k].idx = hi_b[6:3];
                dec.slots[k].val = {hi_b[2:0], lo_b};
            end else begin
                dec.slots[k].idx = hi_b[5:2];
                dec.slots[k].val = {1'b0, hi_b[1:0], lo_b};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            last_time_reg <= '0;
        end else if (byte_en) begin
            pos_reg       <= pos_next;
            last_time_reg <= time_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_en) begin
            bytes_reg[pos_eff] <= rx_byte;
        end
    end

    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.decode |=> pos_reg == POS_W'(LAST_POS))
        else $error("position left the last byte after a decode");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(LAST_POS))
        else $error("frame position beyond frame length");

endmodule

### rtl/rcfd_chan_store.sv
`timescale 1ns / 1ps

module rcfd_chan_store
    import rcfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rcfd_decode_t dec,
    input  logic [3:0]   read_channel,
    input  rcfd_cfg_t    cfg,
    output logic [15:0]  channel_value
);

    logic [VAL_W-1:0] store_reg  [MAX_CHANNELS];
    logic [VAL_W-1:0] store_next [MAX_CHANNELS];
    logic [VAL_W-1:0] sel;
    logic [11:0]      sum;

    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            store_next[i] = store_reg[i];
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (dec.decode && dec.slots[k].idx == CH_W'(i)) begin
                    store_next[i] = dec.slots[k].val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_comb begin
        sel = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (read_channel == CH_W'(i)) begin
                sel = store_reg[i];
            end
        end
        sum = PULSE_OFFSET + {1'b0, sel};
        if (read_channel >= cfg.channels_in_use
            || {1'b0, read_channel} >= 5'(MAX_CHANNELS)) begin
            channel_value = cfg.min_command;
        end else if (cfg.hires_mode) begin
            channel_value = {4'd0, sum};
        end else begin
            channel_value = {3'd0, sum, 1'b0};
        end
    end

endmodule

### rtl/satellite_rc_frame_decoder.sv
`timescale 1ns / 1ps
// Path: an accepted s_data item is taken into the input register, then the result register drives m_valid;
// a held result keeps the input register full and s_ready low until m_ready.
// One transaction per cycle while no result is held by a low m_ready; each item is handled
// in a single pass through the frame assembler and channel store.
// Reset: synchronous, active low; clears configuration to defaults, frame position,
// last byte time and channel store. Frame byte store is not reset.

module satellite_rc_frame_decoder
    import rcfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rcfd_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rcfd_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    rcfd_cfg_t    cfg_reg;
    rcfd_in_t     in_data_reg;
    logic         in_vld_reg;
    rcfd_out_t    out_data_reg, out_data_next;
    logic         out_vld_reg;
    logic         adv;
    logic         byte_en;
    logic         at_last;
    rcfd_decode_t dec;
    logic [15:0]  rd_value;

    assign cfg_ready = 1'b1;
    assign adv       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || adv;
    assign byte_en   = adv && (in_data_reg.kind == KIND_BYTE);
    assign m_valid   = out_vld_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hires_mode      <= 1'b0;
            cfg_reg.channels_in_use <= CHANNELS_RESET;
            cfg_reg.min_command     <= '0;
            cfg_reg.resync_gap_us   <= RESYNC_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HIRES_MODE:  cfg_reg.hires_mode      <= cfg_data[0];
                REG_CHANNELS:    cfg_reg.channels_in_use <= cfg_data[3:0];
                REG_MIN_COMMAND: cfg_reg.min_command     <= cfg_data;
                REG_RESYNC_GAP:  cfg_reg.resync_gap_us   <= cfg_data;
                default: ;
            endcase
        end
    end

    rcfd_frame_asm u_frame_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (in_data_reg.rx_byte),
        .time_us (in_data_reg.time_us),
        .cfg     (cfg_reg),
        .at_last (at_last),
        .dec     (dec)
    );

    rcfd_chan_store u_chan_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dec           (dec),
        .read_channel  (in_data_reg.read_channel),
        .cfg           (cfg_reg),
        .channel_value (rd_value)
    );

    always_comb begin
        if (in_data_reg.kind == KIND_BYTE) begin
            out_data_next.frame_done    = at_last;
            out_data_next.channel_value = '0;
        end else begin
            out_data_next.frame_done    = 1'b0;
            out_data_next.channel_value = rd_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= out_data_next;
        end
    end

    a_done_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_data_reg.frame_done |-> out_data_reg.channel_value == '0)
        else $error("frame_done result carries a channel value");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !adv |=> in_vld_reg && $stable(in_data_reg))
        else $error("stalled input transaction lost");

endmodule
